// ===== hw/rtl/ckce_pkg.sv =====
// shared constants and helpers for the canonical k-mer compact encoder
`default_nettype none

package ckce_pkg;

    localparam int MAX_KMER_LEN = 15;
    localparam int KLEN_W       = 4;
    localparam int KMER_W       = 2 * MAX_KMER_LEN;
    localparam int CODE_W       = 2 * MAX_KMER_LEN;
    localparam int TDATA_W      = ((KMER_W + 7) / 8) * 8;
    localparam int NUM_PAIRS    = MAX_KMER_LEN / 2;
    localparam int SHIFT_W      = $clog2(KMER_W + 1);
    localparam int PAIR_W       = $clog2(NUM_PAIRS + 1);

    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(MAX_KMER_LEN);

    typedef logic [1:0] nuc_t;

    // 4-bit index of a mismatched outer pair (left l, right complement r)
    function automatic logic [3:0] pair_index(input nuc_t l, input nuc_t r);
        logic [3:0] lw;
        logic [3:0] rw;
        logic [3:0] tri_num;
        begin
            lw      = {2'b00, l};
            rw      = {2'b00, r};
            tri_num = 4'((lw * (lw + 4'd1)) >> 1);
            return (lw << 2) - tri_num + rw - lw - 4'd1 + 4'd4;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/canonical_kmer_compact_encoder.sv =====
// Streams packed k-mers in and returns one compact code per k-mer. Each k-mer
// (2 bits per nucleotide, A0 C1 G2 T3, first nucleotide highest) is taken into
// an input register, encoded by one level of combinational logic and held in
// an output register, so the block sustains one k-mer per clock cycle unless
// m_axis_tready stalls the output; a stall holds the k-mer in the input
// register until the output register frees. That single encode stage between
// the two registers sets the rate. The k-mer length k (1..15) is set through
// the cfg port and resets to 15; change it only while no k-mer is in flight.
// Bits of the input at or above bit 2k are ignored.
`default_nettype none

module canonical_kmer_compact_encoder (
    input  wire                               aclk,
    input  wire                               aresetn,
    // config write channel: kmer_length
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [ckce_pkg::KLEN_W-1:0]       cfg_data,
    // tdata: canonical_kmer [29:0], zero pad above
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [ckce_pkg::TDATA_W-1:0]      s_axis_tdata,
    // tdata: compact_code [29:0], zero pad above
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [ckce_pkg::TDATA_W-1:0]      m_axis_tdata
);
    import ckce_pkg::*;

    logic [KLEN_W-1:0] kmer_length_reg;
    logic              in_valid_reg;
    logic [KMER_W-1:0] kmer_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;

    logic out_free;
    logic in_advance;
    logic in_xfer;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_advance    = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= KLEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            kmer_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (in_advance) begin
                in_valid_reg <= 1'b0;
            end
            if (in_advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kmer_reg <= s_axis_tdata[KMER_W-1:0];
        end
        if (in_advance) begin
            code_reg <= code_next;
        end
    end

    // encode: outer palindromic pairs, first mismatch index, shifted middle, offset
    always_comb begin
        logic [CODE_W-1:0] code_v;
        logic              found;
        logic [PAIR_W-1:0] m_pair;
        logic [3:0]        idx_nib;
        nuc_t              r_sel;
        nuc_t              l_sel;
        logic [SHIFT_W-1:0] l_pos;
        logic [SHIFT_W-1:0] idx_pos;
        logic [KLEN_W-1:0] i_end;
        logic [SHIFT_W-1:0] lo_b;
        logic [SHIFT_W-1:0] hi_b;
        logic [SHIFT_W-1:0] hi_sh;
        logic [SHIFT_W-1:0] lo_sh;
        logic [31:0]       mask;
        logic [31:0]       mid;
        logic [31:0]       off;
        logic [31:0]       diff;

        code_v  = '0;
        found   = 1'b0;
        m_pair  = '0;
        idx_nib = '0;
        r_sel   = '0;
        l_sel   = '0;
        l_pos   = '0;

        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (!found && (KLEN_W'(2 * p + 1) < kmer_length_reg)) begin
                r_sel = ~kmer_reg[2*p +: 2];
                l_pos = SHIFT_W'(2 * (int'(kmer_length_reg) - p - 1));
                l_sel = 2'(kmer_reg >> l_pos);
                if (r_sel == l_sel) begin
                    code_v[2*p +: 2] = r_sel;
                end else begin
                    found   = 1'b1;
                    m_pair  = PAIR_W'(p);
                    idx_nib = pair_index(l_sel, r_sel);
                end
            end
        end

        idx_pos = SHIFT_W'(2 * (int'(kmer_length_reg) - int'(m_pair) - 2));
        if (found) begin
            code_v = code_v | (CODE_W'(idx_nib) << idx_pos);
        end

        i_end = found ? KLEN_W'(m_pair) + KLEN_W'(1) : (kmer_length_reg >> 1);
        lo_b  = SHIFT_W'(2 * int'(i_end));
        hi_b  = SHIFT_W'(2 * int'(kmer_length_reg) - 2 * int'(i_end));
        mask  = (32'hFFFF_FFFF << lo_b) & ~(32'hFFFF_FFFF << hi_b);
        mid   = (32'(kmer_reg) & mask) >> (found ? 2 : 0);
        code_v = code_v | mid[CODE_W-1:0];

        hi_sh = SHIFT_W'(2 * (int'(kmer_length_reg) - int'(i_end)));
        lo_sh = SHIFT_W'(int'(kmer_length_reg) + int'(kmer_length_reg[0]));
        off   = found ? (((32'd1 << hi_sh) - (32'd1 << lo_sh)) >> 1) : 32'd0;
        diff  = 32'(code_v) - off;
        code_next = diff[CODE_W-1:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(code_reg);

`ifndef SYNTHESIS
    // input stage only stalls when both stages hold items
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // an input transfer always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> in_valid_reg)
        else $error("accepted k-mer lost");

    // an advancing item reaches the output with its encoded value
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_advance |=> (out_valid_reg && code_reg == $past(code_next)))
        else $error("encoded value not captured");

    // reset restores the full k-mer length
    assert property (@(posedge aclk)
        !aresetn |=> kmer_length_reg == KLEN_RESET)
        else $error("kmer length not reset");
`endif

endmodule

`default_nettype wire
